>>> hw/rtl/snre_pkg.sv
// shared types and constants of the sensor node routing engine
package snre_pkg;

  localparam int UP_ENTRIES   = 4;
  localparam int DOWN_ENTRIES = 8;
  localparam int MAX_RESULTS  = 12;
  localparam int QUEUE_DEPTH  = 4;

  localparam int UP_CW   = $clog2(UP_ENTRIES + 1);
  localparam int DOWN_CW = $clog2(DOWN_ENTRIES + 1);
  localparam int UP_IW   = (UP_ENTRIES > 1) ? $clog2(UP_ENTRIES) : 1;
  localparam int DOWN_IW = (DOWN_ENTRIES > 1) ? $clog2(DOWN_ENTRIES) : 1;
  localparam int SCAN_W  = (UP_CW > DOWN_CW) ? UP_CW : DOWN_CW;
  localparam int RES_CW  = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_FORWARD   = 3'd0;
  localparam logic [2:0] KIND_ANNOUNCE  = 3'd1;
  localparam logic [2:0] KIND_DISCOVER  = 3'd2;
  localparam logic [2:0] KIND_ASSOCIATE = 3'd3;
  localparam logic [2:0] KIND_ACK       = 3'd4;
  localparam logic [2:0] KIND_MEASURE   = 3'd5;

  localparam logic [2:0] MT_DISCOVER  = 3'd0;
  localparam logic [2:0] MT_ANNOUNCE  = 3'd1;
  localparam logic [2:0] MT_ASSOCIATE = 3'd2;
  localparam logic [2:0] MT_ACK       = 3'd3;

  localparam logic [7:0] PROT_CTRL = 8'd1;
  localparam logic [7:0] PROT_MEAS = 8'd2;

  localparam logic [5:0] SEC_MAX     = 6'd59;
  localparam logic [6:0] SEC_PER_MIN = 7'd60;

  localparam logic [2:0] REG_NODE_ID          = 3'd0;
  localparam logic [2:0] REG_BROADCAST_HOP    = 3'd1;
  localparam logic [2:0] REG_DEST_ALL         = 3'd2;
  localparam logic [2:0] REG_SECONDS_PER_TICK = 3'd3;
  localparam logic [2:0] REG_DISCOVER_MINUTES = 3'd4;
  localparam logic [2:0] REG_ANNOUNCE_MINUTES = 3'd5;
  localparam logic [2:0] REG_MEASURE_MINUTES  = 3'd6;

  localparam logic [7:0] RST_NODE_ID          = 8'd0;
  localparam logic [7:0] RST_BROADCAST_HOP    = 8'd255;
  localparam logic [7:0] RST_DEST_ALL         = 8'd254;
  localparam logic [5:0] RST_SECONDS_PER_TICK = 6'd1;
  localparam logic [7:0] RST_DISCOVER_MINUTES = 8'd5;
  localparam logic [7:0] RST_ANNOUNCE_MINUTES = 8'd10;
  localparam logic [7:0] RST_MEASURE_MINUTES  = 8'd1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] next_hop;
    logic [7:0] dest;
    logic [7:0] orig;
    logic [7:0] prot;
    logic [2:0] msg_type;
    logic [7:0] hop_count;
    logic [7:0] gateway;
    logic [7:0] msg_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_next_hop;
    logic [7:0] out_dest;
    logic [7:0] out_orig;
    logic [7:0] out_prot;
    logic [2:0] out_type;
    logic [7:0] out_hops;
    logic [7:0] out_gateway;
    logic [7:0] out_id;
    logic       associated;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] node_id;
    logic [7:0] broadcast_hop;
    logic [7:0] dest_all;
    logic [5:0] seconds_per_tick;
    logic [7:0] discover_minutes;
    logic [7:0] announce_minutes;
    logic [7:0] measure_minutes;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } push_t;

endpackage

>>> hw/rtl/snre_front.sv
// front sequencer: accepts items, scans the tables, updates state, produces result words
module snre_front (
  input  logic              clk,
  input  logic              rst,
  input  snre_pkg::cfg_t    cfg,
  input  logic              start,
  input  snre_pkg::in_word_t item,
  output logic              busy,
  input  logic              q_full,
  output snre_pkg::push_t   push
);
  import snre_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHK   = 7'b0000010,
    S_FWD   = 7'b0000100,
    S_RES   = 7'b0001000,
    S_ANN   = 7'b0010000,
    S_MEAS  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state;
  in_word_t it;
  logic ctl, fwd_pend, fwd_down, ann_after, found, step_assoc, link_state;
  logic [5:0] second_count;
  logic [7:0] discover_left, announce_left, measure_left;
  logic [7:0] up_gw [UP_ENTRIES];
  logic [7:0] up_nh [UP_ENTRIES];
  logic [7:0] up_hops [UP_ENTRIES];
  logic [UP_CW-1:0] up_count;
  logic [7:0] down_node [DOWN_ENTRIES];
  logic [7:0] down_gw [DOWN_ENTRIES];
  logic [DOWN_CW-1:0] down_count;
  logic [SCAN_W-1:0] idx;
  logic [RES_CW-1:0] n;
  out_word_t pend;
  logic pend_v;

  logic accept, advance, em_v, emit_ok;
  out_word_t em_w;
  logic [UP_IW-1:0] up_i;
  logic [DOWN_IW-1:0] dn_i;
  logic up_lim, dn_lim, fwd_lim, fwd_hit, chk_lim, chk_hit, chk_up;
  logic [5:0] inc;
  logic [6:0] s_sum, s_new;
  logic min_roll, hdr_match, acc_v, ctl_v, need_chk, fwd_v, fwd_dn_v;
  logic [7:0] dl_dec, al_dec, ml_dec;

  function automatic state_t post_fwd(logic c, logic [2:0] t, logic lk);
    state_t r;
    r = S_FLUSH;
    if (c) begin
      if (t == MT_DISCOVER) begin
        r = lk ? S_ANN : S_FLUSH;
      end else if (t == MT_ANNOUNCE || t == MT_ASSOCIATE || t == MT_ACK) begin
        r = S_RES;
      end
    end
    return r;
  endfunction

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign advance = !q_full;
  assign up_i    = idx[UP_IW-1:0];
  assign dn_i    = idx[DOWN_IW-1:0];
  assign up_lim  = idx < SCAN_W'(up_count);
  assign dn_lim  = idx < SCAN_W'(down_count);
  assign fwd_lim = fwd_down ? dn_lim : up_lim;
  assign fwd_hit = fwd_down ? (down_gw[dn_i] == it.orig) : (up_gw[up_i] == it.dest);
  assign chk_up  = (it.msg_type != MT_ASSOCIATE);
  assign chk_lim = chk_up ? up_lim : dn_lim;
  assign chk_hit = chk_up
                 ? (up_gw[up_i] == ((it.msg_type == MT_ACK) ? it.gateway : it.orig))
                 : (down_node[dn_i] == it.orig && down_gw[dn_i] == it.gateway);

  assign inc      = (cfg.seconds_per_tick > SEC_MAX) ? SEC_MAX : cfg.seconds_per_tick;
  assign s_sum    = {1'b0, second_count} + {1'b0, inc};
  assign min_roll = s_sum > {1'b0, SEC_MAX};
  assign s_new    = min_roll ? s_sum - SEC_PER_MIN : s_sum;
  assign dl_dec   = discover_left - 8'd1;
  assign al_dec   = announce_left - 8'd1;
  assign ml_dec   = measure_left - 8'd1;

  assign hdr_match = (item.next_hop == cfg.node_id) || (item.next_hop == cfg.broadcast_hop);
  assign fwd_dn_v  = !(item.dest == cfg.node_id || item.dest == cfg.dest_all)
                     && (item.dest == cfg.broadcast_hop);
  assign acc_v     = (item.dest == cfg.node_id) || (item.dest == cfg.dest_all) || fwd_dn_v;
  assign fwd_v     = !(item.dest == cfg.node_id || item.dest == cfg.dest_all);
  assign ctl_v     = acc_v && (item.prot == PROT_CTRL);
  assign need_chk  = ctl_v && (item.msg_type == MT_ANNOUNCE || item.msg_type == MT_ASSOCIATE
                              || item.msg_type == MT_ACK);

  always_comb begin
    em_v = 1'b0;
    em_w = '0;
    em_w.associated = step_assoc;
    em_w.out_orig   = cfg.node_id;
    case (state)
      S_IDLE: begin
        if (accept && item.cmd && min_roll && !link_state && dl_dec == 8'd0) begin
          em_v = 1'b1;
          em_w.kind = KIND_DISCOVER;
          em_w.out_next_hop = cfg.broadcast_hop;
          em_w.out_dest = cfg.dest_all;
          em_w.out_prot = PROT_CTRL;
          em_w.out_type = MT_DISCOVER;
          em_w.associated = link_state;
        end
      end
      S_FWD: begin
        if (advance && fwd_lim && fwd_hit) begin
          em_v = 1'b1;
          em_w.kind = KIND_FORWARD;
          em_w.out_next_hop = fwd_down ? down_node[dn_i] : up_nh[up_i];
          em_w.out_dest = it.dest;
          em_w.out_orig = it.orig;
          em_w.out_prot = it.prot;
          em_w.out_type = it.msg_type;
          em_w.out_hops = it.hop_count;
          em_w.out_gateway = it.gateway;
          em_w.out_id = it.msg_id;
        end
      end
      S_RES: begin
        em_w.out_next_hop = it.orig;
        em_w.out_dest = it.orig;
        em_w.out_prot = it.prot;
        em_w.out_hops = it.hop_count;
        em_w.out_gateway = it.gateway;
        em_w.out_id = it.msg_id;
        if (it.msg_type == MT_ANNOUNCE) begin
          em_w.kind = KIND_ASSOCIATE;
          em_w.out_type = MT_ASSOCIATE;
          em_v = advance && !found && (up_count < UP_CW'(UP_ENTRIES));
        end else if (it.msg_type == MT_ASSOCIATE) begin
          em_w.kind = KIND_ACK;
          em_w.out_type = MT_ACK;
          em_v = advance && (found || down_count < DOWN_CW'(DOWN_ENTRIES));
        end
      end
      S_ANN: begin
        if (advance && up_lim) begin
          em_v = 1'b1;
          em_w.kind = KIND_ANNOUNCE;
          em_w.out_next_hop = cfg.broadcast_hop;
          em_w.out_dest = cfg.dest_all;
          em_w.out_prot = PROT_CTRL;
          em_w.out_type = MT_ANNOUNCE;
          em_w.out_hops = up_hops[up_i];
          em_w.out_gateway = up_gw[up_i];
        end
      end
      S_MEAS: begin
        if (advance && up_lim) begin
          em_v = 1'b1;
          em_w.kind = KIND_MEASURE;
          em_w.out_next_hop = up_nh[up_i];
          em_w.out_dest = up_gw[up_i];
          em_w.out_prot = PROT_MEAS;
        end
      end
      default: begin
        em_v = 1'b0;
      end
    endcase
  end

  assign emit_ok = em_v && (n < RES_CW'(MAX_RESULTS));

  always_comb begin
    push.valid = (emit_ok && pend_v) || (state == S_FLUSH && pend_v && advance);
    push.word = pend;
    push.word.last = (state == S_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      pend <= em_w;
    end
    if (state == S_RES && advance && !found) begin
      if (it.msg_type == MT_ASSOCIATE && down_count < DOWN_CW'(DOWN_ENTRIES)) begin
        down_node[down_count[DOWN_IW-1:0]] <= it.orig;
        down_gw[down_count[DOWN_IW-1:0]] <= it.gateway;
      end
      if (it.msg_type == MT_ACK) begin
        up_gw[up_count[UP_IW-1:0]] <= it.gateway;
        up_nh[up_count[UP_IW-1:0]] <= it.orig;
        up_hops[up_count[UP_IW-1:0]] <= (it.hop_count == 8'd255) ? 8'd255
                                        : it.hop_count + 8'd1;
      end
    end
    if (accept) begin
      it <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      link_state <= 1'b0;
      second_count <= '0;
      discover_left <= RST_DISCOVER_MINUTES;
      announce_left <= RST_ANNOUNCE_MINUTES;
      measure_left <= RST_MEASURE_MINUTES;
      up_count <= '0;
      down_count <= '0;
      idx <= '0;
      n <= '0;
      pend_v <= 1'b0;
      ctl <= 1'b0;
      fwd_pend <= 1'b0;
      fwd_down <= 1'b0;
      ann_after <= 1'b0;
      found <= 1'b0;
      step_assoc <= 1'b0;
    end else begin
      if (emit_ok) begin
        pend_v <= 1'b1;
        n <= n + RES_CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx <= '0;
            step_assoc <= link_state;
            ann_after <= 1'b0;
            if (!emit_ok) begin
              n <= '0;
            end else begin
              n <= RES_CW'(1);
            end
            if (item.cmd) begin
              second_count <= s_new[5:0];
              state <= S_FLUSH;
              if (min_roll) begin
                if (!link_state) begin
                  discover_left <= (dl_dec == 8'd0) ? cfg.discover_minutes : dl_dec;
                end else begin
                  announce_left <= (al_dec == 8'd0) ? cfg.announce_minutes : al_dec;
                  measure_left <= (ml_dec == 8'd0) ? cfg.measure_minutes : ml_dec;
                  ann_after <= (al_dec == 8'd0);
                  if (ml_dec == 8'd0) begin
                    state <= S_MEAS;
                  end else if (al_dec == 8'd0) begin
                    state <= S_ANN;
                  end
                end
              end
            end else if (hdr_match) begin
              ctl <= ctl_v;
              fwd_pend <= fwd_v;
              fwd_down <= fwd_dn_v;
              if (need_chk && item.msg_type == MT_ACK && up_count >= UP_CW'(UP_ENTRIES)) begin
                up_count <= '0;
              end
              if (need_chk) begin
                state <= S_CHK;
              end else if (fwd_v) begin
                state <= S_FWD;
              end else begin
                state <= post_fwd(ctl_v, item.msg_type, link_state);
              end
            end
          end
        end
        S_CHK: begin
          if (!chk_lim || chk_hit) begin
            found <= chk_lim && chk_hit;
            idx <= '0;
            if (it.msg_type == MT_ACK && !(chk_lim && chk_hit)) begin
              step_assoc <= 1'b1;
            end
            state <= fwd_pend ? S_FWD : post_fwd(ctl, it.msg_type, link_state);
          end else begin
            idx <= idx + SCAN_W'(1);
          end
        end
        S_FWD: begin
          if (advance) begin
            if (fwd_lim) begin
              idx <= idx + SCAN_W'(1);
            end else begin
              idx <= '0;
              state <= post_fwd(ctl, it.msg_type, link_state);
            end
          end
        end
        S_RES: begin
          if (advance) begin
            if (!found && it.msg_type == MT_ASSOCIATE && down_count < DOWN_CW'(DOWN_ENTRIES)) begin
              down_count <= down_count + DOWN_CW'(1);
            end
            if (!found && it.msg_type == MT_ACK) begin
              up_count <= up_count + UP_CW'(1);
              link_state <= 1'b1;
            end
            state <= S_FLUSH;
          end
        end
        S_ANN: begin
          if (advance) begin
            if (up_lim) begin
              idx <= idx + SCAN_W'(1);
            end else begin
              idx <= '0;
              state <= S_FLUSH;
            end
          end
        end
        S_MEAS: begin
          if (advance) begin
            if (up_lim) begin
              idx <= idx + SCAN_W'(1);
            end else begin
              idx <= '0;
              state <= ann_after ? S_ANN : S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (advance) begin
            pend_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/snre_back.sv
// result queue and output register, one word delivered per cycle
module snre_back (
  input  logic                clk,
  input  logic                rst,
  input  snre_pkg::push_t     push,
  output logic                q_full,
  output logic                done,
  output snre_pkg::out_word_t result
);
  import snre_pkg::*;

  out_word_t mem [QUEUE_DEPTH];
  logic [QUEUE_IW-1:0] head, tail;
  logic [QUEUE_CW-1:0] cnt;
  logic pop;

  assign q_full = (cnt == QUEUE_CW'(QUEUE_DEPTH));
  assign pop = (cnt != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[tail] <= push.word;
    end
    if (pop) begin
      result <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= pop;
      if (push.valid) begin
        tail <= (tail == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0 : tail + QUEUE_IW'(1);
      end
      if (pop) begin
        head <= (head == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0 : head + QUEUE_IW'(1);
      end
      if (push.valid && !pop) begin
        cnt <= cnt + QUEUE_CW'(1);
      end else if (!push.valid && pop) begin
        cnt <= cnt - QUEUE_CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/sensor_node_routing_engine.sv
// Sensor node routing engine: takes a received header or a time tick while busy is low and
// start is high. A header for another node leaves the engine idle. A tick passes through
// the accept and a final flush state, with a measurement round, an announce round or both
// in between where they fall due. A header passes through the accept, a scan for each that
// it needs (membership check, forward scan, announce round), a reply state where there is a
// reply, and a final flush state; the front sequencer reads one table entry per cycle, in the
// forward scan and rounds only while the queue is not full. The queue drains one word per
// cycle, as fast as the front fills it, so it adds no stall. Result words leave the queue
// one per cycle, each shown for one cycle with done high; the receiver cannot stall, and
// the last word of an item carries last.
module sensor_node_routing_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  snre_pkg::in_word_t  item,
  output logic                done,
  output snre_pkg::out_word_t result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import snre_pkg::*;

  cfg_t cfg;
  push_t push;
  logic q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id <= RST_NODE_ID;
      cfg.broadcast_hop <= RST_BROADCAST_HOP;
      cfg.dest_all <= RST_DEST_ALL;
      cfg.seconds_per_tick <= RST_SECONDS_PER_TICK;
      cfg.discover_minutes <= RST_DISCOVER_MINUTES;
      cfg.announce_minutes <= RST_ANNOUNCE_MINUTES;
      cfg.measure_minutes <= RST_MEASURE_MINUTES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_ID:          cfg.node_id <= cfg_data;
        REG_BROADCAST_HOP:    cfg.broadcast_hop <= cfg_data;
        REG_DEST_ALL:         cfg.dest_all <= cfg_data;
        REG_SECONDS_PER_TICK: cfg.seconds_per_tick <= cfg_data[5:0];
        REG_DISCOVER_MINUTES: cfg.discover_minutes <= cfg_data;
        REG_ANNOUNCE_MINUTES: cfg.announce_minutes <= cfg_data;
        REG_MEASURE_MINUTES:  cfg.measure_minutes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  snre_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .q_full (q_full),
    .push   (push)
  );

  snre_back u_back (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .q_full (q_full),
    .done   (done),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full) else $error("word pushed into full queue");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    push.valid && push.word.last |=> !busy) else $error("busy after last word");

  a_foreign_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.cmd && item.next_hop != cfg.node_id
    && item.next_hop != cfg.broadcast_hop |=> !busy)
    else $error("foreign header kept engine busy");
`endif

endmodule
